[hdl/ccache_pkg.sv]
// Shared widths, command and mode codes, and the structs passed between
// the cache blocks. No dependencies.
`timescale 1ns / 1ps

package ccache_pkg;

	localparam int ADDR_W    = 11;
	localparam int DATA_W    = 32;
	localparam int CNT_W     = 32;
	localparam int TAG_W     = 11;
	localparam int CMD_W     = 2;
	localparam int MODE_W    = 2;
	localparam int MEM_DEPTH = 2048;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STORE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_NOP   = 2'd2;

	localparam logic [MODE_W-1:0] MODE_DM = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FA = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SA = 2'd2;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic              hit;
		logic              load_miss;
		logic [DATA_W-1:0] rdata;
	} lookup_t;

endpackage

[hdl/ccache_mem.sv]
// Backing store: single-port-write, registered-read word RAM with a
// zero-fill sweep after reset. Depends on ccache_pkg.
`timescale 1ns / 1ps

module ccache_mem import ccache_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_wr_t           wr,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	output logic              busy
);

	logic [DATA_W-1:0] mem_q [MEM_DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_addr_q] <= '0;
		end else if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clr_busy_q;

endmodule

[hdl/ccache_lines.sv]
// Cache line store (valid, tag, data, LRU rank) with tag match, victim
// select and LRU promote for all three modes. Depends on ccache_pkg.
`timescale 1ns / 1ps

module ccache_lines import ccache_pkg::*; #(
	parameter int LINES    = 16,
	parameter int SET_WAYS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd,
	input  logic [MODE_W-1:0] mode,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [ADDR_W-1:0] addr,
	input  logic [ADDR_W-1:0] dm_quo,
	input  logic [ADDR_W-1:0] sa_quo,
	input  logic [DATA_W-1:0] wdata,
	input  logic [DATA_W-1:0] mem_rdata,
	output lookup_t           res
);

	localparam int SET_COUNT = (LINES / SET_WAYS > 0) ? (LINES / SET_WAYS) : 1;
	localparam int LIDX_W    = $clog2(LINES);
	localparam int SET_W     = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int RANK_W    = $clog2((LINES > SET_WAYS) ? LINES : SET_WAYS);
	localparam logic [RANK_W-1:0] FA_TOP = RANK_W'(LINES - 1);
	localparam logic [RANK_W-1:0] SA_TOP = RANK_W'(SET_WAYS - 1);

	logic [LINES-1:0]  valid_q;
	logic [TAG_W-1:0]  tag_q  [LINES];
	logic [DATA_W-1:0] data_q [LINES];
	logic [RANK_W-1:0] rank_q [LINES];

	logic [ADDR_W-1:0] dm_rem, sa_rem;
	logic [LIDX_W-1:0] line_idx;
	logic [SET_W-1:0]  set_idx;
	logic [TAG_W-1:0]  cur_tag;
	logic              is_dm, is_fa, is_load, is_store;
	logic [LINES-1:0]  grp, match, is_min;
	logic [LIDX_W-1:0] hit_e, vic_e, sel_e;
	logic              found;
	logic [RANK_W-1:0] old_rank, top_rank;
	logic              promote, fill, st_hit;

	// quotients come in registered; remainders by constant multiply
	assign dm_rem   = addr - dm_quo * ADDR_W'(LINES);
	assign sa_rem   = addr - sa_quo * ADDR_W'(SET_COUNT);
	assign line_idx = dm_rem[LIDX_W-1:0];
	assign set_idx  = sa_rem[SET_W-1:0];

	assign is_dm    = (mode == MODE_DM);
	assign is_fa    = (mode == MODE_FA);
	assign is_load  = (cmd == CMD_LOAD);
	assign is_store = (cmd == CMD_STORE);

	always_comb begin
		unique case (mode)
			MODE_DM: cur_tag = dm_quo;
			MODE_FA: cur_tag = addr;
			default: cur_tag = sa_quo;
		endcase
	end

	for (genvar g = 0; g < LINES; g++) begin : g_line
		localparam int GSET = g % SET_COUNT;
		logic [LINES-1:0] below;

		assign grp[g] = is_fa |
			(is_dm ? (line_idx == LIDX_W'(g)) : (set_idx == SET_W'(GSET)));
		assign match[g] = grp[g] & valid_q[g] & (tag_q[g] == cur_tag);

		for (genvar j = 0; j < LINES; j++) begin : g_cmp
			assign below[j] = grp[j] && (rank_q[j] < rank_q[g]);
		end
		assign is_min[g] = grp[g] && !(|below);
	end

	// highest matching line wins; victim is the lowest-index line of minimum rank
	always_comb begin
		hit_e = '0;
		for (int i = 0; i < LINES; i++) begin
			if (match[i]) begin
				hit_e = LIDX_W'(i);
			end
		end
		vic_e = '0;
		for (int i = LINES - 1; i >= 0; i--) begin
			if (is_min[i]) begin
				vic_e = LIDX_W'(i);
			end
		end
	end

	assign found    = |match;
	assign sel_e    = found ? hit_e : (is_dm ? line_idx : vic_e);
	assign old_rank = rank_q[sel_e];
	assign top_rank = is_fa ? FA_TOP : SA_TOP;

	assign promote = upd & is_load & ~is_dm;
	assign fill    = upd & is_load & ~found;
	assign st_hit  = upd & is_store & found;

	assign res.hit       = found & (is_load | is_store);
	assign res.load_miss = is_load & ~found;
	assign res.rdata     = !is_load ? '0 : (found ? data_q[hit_e] : mem_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < LINES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (fill) begin
				valid_q[sel_e] <= 1'b1;
			end
			if (promote) begin
				for (int i = 0; i < LINES; i++) begin
					if (LIDX_W'(i) == sel_e) begin
						rank_q[i] <= top_rank;
					end else if (grp[i] && rank_q[i] > old_rank) begin
						rank_q[i] <= rank_q[i] - 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fill) begin
			tag_q[sel_e]  <= cur_tag;
			data_q[sel_e] <= mem_rdata;
		end else if (st_hit) begin
			data_q[sel_e] <= wdata;
		end
	end

endmodule

[hdl/cache_controller_dm_fa_sa_lru.sv]
// Channel   | Dir | Handshake            | Payload
// cfg       | in  | cfg_valid/cfg_ready  | cfg_data (cache mode)
// in        | in  | in_valid/in_ready    | command, address, write_data
// out       | out | out_valid/out_ready  | hit, read_data, miss_count
//
// One item per cycle sustained while the output is not stalled and the RAM
// clear is done; a result passes the input register, then the result register,
// where it is shown and from which it can transfer.
// The RAM read is issued at the input transfer; a store still in stage 1
// to the same address is forwarded.
// After reset the backing RAM is zero-filled over all MEM_DEPTH (2048) words,
// with in_ready low; cfg writes are taken throughout.
// A stalled output holds stage 1, which in turn drops in_ready.
//
// Top level of the cache controller. Depends on ccache_pkg, ccache_mem,
// ccache_lines.
`timescale 1ns / 1ps

module cache_controller_dm_fa_sa_lru import ccache_pkg::*; #(
	parameter int LINES    = 16,
	parameter int SET_WAYS = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [MODE_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         command,
	input  logic [ADDR_W-1:0]        address,
	input  logic signed [DATA_W-1:0] write_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     hit,
	output logic signed [DATA_W-1:0] read_data,
	output logic [CNT_W-1:0]         miss_count
);

	localparam int SET_COUNT = (LINES / SET_WAYS > 0) ? (LINES / SET_WAYS) : 1;
	// reciprocal multiply: exact floor division for any ADDR_W-bit address
	localparam int DM_SH  = ADDR_W + $clog2(LINES);
	localparam int SA_SH  = ADDR_W + $clog2(SET_COUNT);
	localparam int DM_MUL = ((1 << DM_SH) + LINES - 1) / LINES;
	localparam int SA_MUL = ((1 << SA_SH) + SET_COUNT - 1) / SET_COUNT;
	localparam int MUL_W  = ADDR_W + 2;
	localparam int PROD_W = ADDR_W + MUL_W;

	logic [MODE_W-1:0] mode_q;

	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [ADDR_W-1:0] addr_s1, dmq_s1, saq_s1;
	logic [DATA_W-1:0] wdata_s1;
	logic              fwd_s1;
	logic [DATA_W-1:0] fwd_data_s1;

	logic              valid_s2, hit_s2;
	logic [DATA_W-1:0] rdata_s2;
	logic [CNT_W-1:0]  miss_s2;
	logic [CNT_W-1:0]  miss_total_q, miss_total_nx;

	logic              in_fire, adv_s1, mem_busy, fwd_hit;
	logic [PROD_W-1:0] dm_prod, sa_prod;
	logic [DATA_W-1:0] ram_rdata, mem_rdata;
	mem_wr_t           mem_wr;
	lookup_t           lk;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DM;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !mem_busy && (!valid_s1 || adv_s1);
	assign in_fire  = in_valid && in_ready;

	assign dm_prod = PROD_W'(address) * PROD_W'(DM_MUL);
	assign sa_prod = PROD_W'(address) * PROD_W'(SA_MUL);

	// store leaving stage 1 writes the RAM at the same edge the next read issues
	assign fwd_hit = adv_s1 && (cmd_s1 == CMD_STORE) && (addr_s1 == address);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1      <= command;
			addr_s1     <= address;
			wdata_s1    <= write_data;
			dmq_s1      <= ADDR_W'(dm_prod >> DM_SH);
			saq_s1      <= ADDR_W'(sa_prod >> SA_SH);
			fwd_s1      <= fwd_hit;
			fwd_data_s1 <= wdata_s1;
		end
	end

	assign mem_wr.en   = adv_s1 && (cmd_s1 == CMD_STORE);
	assign mem_wr.addr = addr_s1;
	assign mem_wr.data = wdata_s1;

	ccache_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mem_wr),
		.rd_en   (in_fire),
		.rd_addr (address),
		.rd_data (ram_rdata),
		.busy    (mem_busy)
	);

	assign mem_rdata = fwd_s1 ? fwd_data_s1 : ram_rdata;

	ccache_lines #(
		.LINES    (LINES),
		.SET_WAYS (SET_WAYS)
	) u_lines (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (adv_s1),
		.mode      (mode_q),
		.cmd       (cmd_s1),
		.addr      (addr_s1),
		.dm_quo    (dmq_s1),
		.sa_quo    (saq_s1),
		.wdata     (wdata_s1),
		.mem_rdata (mem_rdata),
		.res       (lk)
	);

	assign miss_total_nx = miss_total_q + CNT_W'(lk.load_miss);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_total_q <= '0;
			valid_s2     <= 1'b0;
		end else begin
			if (adv_s1) begin
				miss_total_q <= miss_total_nx;
				valid_s2     <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			hit_s2   <= lk.hit;
			rdata_s2 <= lk.rdata;
			miss_s2  <= miss_total_nx;
		end
	end

	assign out_valid  = valid_s2;
	assign hit        = hit_s2;
	assign read_data  = $signed(rdata_s2);
	assign miss_count = miss_s2;

endmodule

[hdl/ccache_chk.sv]
// Port-level checker for the cache controller, bound to the top level.
// Depends on ccache_pkg and cache_controller_dm_fa_sa_lru.
`timescale 1ns / 1ps

module ccache_chk import ccache_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cfg_valid,
	input logic                     cfg_ready,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic                     hit,
	input logic signed [DATA_W-1:0] read_data,
	input logic [CNT_W-1:0]         miss_count
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) &&
			$stable(read_data) && $stable(miss_count))
		else $error("result changed while stalled");

	// every input transfer is followed by a result shown on out_valid
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("input transfer produced no result");

	// RAM zero-fill blocks input right after reset
	a_clear_block: assert property (@(posedge clk)
		arst_n && !$past(arst_n) |-> !in_ready)
		else $error("input taken during RAM clear");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("cfg write stalled");

endmodule

bind cache_controller_dm_fa_sa_lru ccache_chk u_ccache_chk (.*);

[sim/cache_controller_dm_fa_sa_lru_tb.sv]
// Testbench for cache_controller_dm_fa_sa_lru: directed cases and random handshake
// stress with a built-in cache/memory predictor checking every result transfer.
// Depends on ccache_pkg and the cache_controller_dm_fa_sa_lru RTL.
`timescale 1ns / 1ps

module cache_controller_dm_fa_sa_lru_tb;
	import ccache_pkg::*;

	localparam int LINES       = 16;
	localparam int SET_WAYS    = 4;
	localparam int SETS        = LINES / SET_WAYS;
	localparam int HOT_N       = 20;
	localparam int PHASE_ITEMS = 190;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	// encodings the package leaves unnamed; both must behave like their neighbors
	localparam logic [CMD_W-1:0]  CMD_SPARE   = 2'd3;
	localparam logic [MODE_W-1:0] MODE_SA_ALT = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} access_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] read_data;
		logic [CNT_W-1:0]         miss_count;
	} reply_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [MODE_W-1:0]        cfg_data = MODE_DM;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [CMD_W-1:0]         command = CMD_NOP;
	logic [ADDR_W-1:0]        address = '0;
	logic signed [DATA_W-1:0] write_data = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     hit;
	logic signed [DATA_W-1:0] read_data;
	logic [CNT_W-1:0]         miss_count;

	cache_controller_dm_fa_sa_lru #(
		.LINES    (LINES),
		.SET_WAYS (SET_WAYS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.address    (address),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.read_data  (read_data),
		.miss_count (miss_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [MODE_W-1:0] shadow_mode = MODE_DM;
	logic              line_ok   [LINES];
	logic [TAG_W-1:0]  line_tag  [LINES];
	logic [DATA_W-1:0] line_word [LINES];
	logic [3:0]        line_rank [LINES];
	logic [DATA_W-1:0] mem_word  [MEM_DEPTH];
	logic [CNT_W-1:0]  miss_total = '0;

	access_t           pending_access [$];
	reply_t            reply_q [$];
	logic [ADDR_W-1:0] hot_addr [HOT_N];

	logic in_taken = 1'b0;
	logic out_taken = 1'b0;
	int   in_wait = 0;
	int   in_calm = 0;
	int   out_hold = 0;
	int   out_calm = 0;
	int   bad_count = 0;
	int   cycle_count = 0;

	initial begin
		for (int i = 0; i < LINES; i++) begin
			line_ok[i] = 1'b0;
			line_tag[i] = '0;
			line_word[i] = '0;
			line_rank[i] = '0;
		end
		for (int i = 0; i < MEM_DEPTH; i++)
			mem_word[i] = '0;
	end

	// fully associative: every line; otherwise the lines of one set
	function automatic bit in_group(input int line, input int set);
		if (shadow_mode == MODE_FA)
			return 1'b1;
		return (line % SETS) == set;
	endfunction

	function automatic void make_recent(input int way, input int set);
		logic [3:0] old;
		if (shadow_mode == MODE_DM)
			return;
		old = line_rank[way];
		for (int i = 0; i < LINES; i++)
			if (in_group(i, set) && line_rank[i] > old)
				line_rank[i] = line_rank[i] - 4'd1;
		line_rank[way] = (shadow_mode == MODE_FA) ? 4'(LINES - 1) : 4'(SET_WAYS - 1);
	endfunction

	function automatic reply_t cache_access(input logic [CMD_W-1:0] cmd,
			input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] wdata);
		reply_t           r;
		logic [TAG_W-1:0] tag;
		int               set;
		int               way;
		bit               found;
		bit               have;
		r = '0;
		set = 0;
		way = 0;
		found = 1'b0;
		if (shadow_mode == MODE_DM) begin
			way = addr % LINES;
			tag = TAG_W'(addr / LINES);
			found = line_ok[way] && line_tag[way] == tag;
		end else begin
			if (shadow_mode == MODE_FA) begin
				tag = addr;
			end else begin
				set = addr % SETS;
				tag = TAG_W'(addr / SETS);
			end
			// last match wins when stale lines from another mode collide
			for (int i = 0; i < LINES; i++)
				if (in_group(i, set) && line_ok[i] && line_tag[i] == tag) begin
					way = i;
					found = 1'b1;
				end
		end
		case (cmd)
			CMD_LOAD: begin
				if (found) begin
					r.read_data = line_word[way];
					make_recent(way, set);
				end else begin
					miss_total = miss_total + 1;
					r.read_data = mem_word[addr];
					if (shadow_mode != MODE_DM) begin
						have = 1'b0;
						for (int i = 0; i < LINES; i++)
							if (in_group(i, set) && (!have || line_rank[i] < line_rank[way])) begin
								way = i;
								have = 1'b1;
							end
						make_recent(way, set);
					end
					line_ok[way] = 1'b1;
					line_tag[way] = tag;
					line_word[way] = r.read_data;
				end
			end
			CMD_STORE: begin
				if (found)
					line_word[way] = wdata;
				mem_word[addr] = wdata;
			end
			default: found = 1'b0;
		endcase
		r.hit = found;
		r.miss_count = miss_total;
		return r;
	endfunction

	// wait before the next transfer; now and then a burst with no idling
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0)
			calm = $urandom_range(8, 40);
		return $urandom_range(0, 15);
	endfunction

	function automatic access_t random_access();
		access_t a;
		int      pick;
		pick = $urandom_range(0, 19);
		if (pick < 12)
			a.cmd = CMD_LOAD;
		else if (pick < 18)
			a.cmd = CMD_STORE;
		else if (pick == 18)
			a.cmd = CMD_NOP;
		else
			a.cmd = CMD_SPARE;
		if ($urandom_range(0, 3) != 0)
			a.addr = hot_addr[$urandom_range(0, HOT_N - 1)];
		else
			a.addr = ADDR_W'($urandom_range(0, MEM_DEPTH - 1));
		case ($urandom_range(0, 15))
			0: a.wdata = 32'h0000_0000;
			1: a.wdata = 32'h7fff_ffff;
			2: a.wdata = 32'h8000_0000;
			3: a.wdata = 32'hffff_ffff;
			default: a.wdata = $urandom;
		endcase
		return a;
	endfunction

	task automatic queue_access(input logic [CMD_W-1:0] cmd, input int addr,
			input logic [DATA_W-1:0] wdata);
		access_t a;
		a.cmd = cmd;
		a.addr = ADDR_W'(addr);
		a.wdata = wdata;
		pending_access = {pending_access, a};
	endtask

	// block is idle once all queued transfers went in and every reply came back
	task automatic drain();
		do
			@(posedge clk);
		while (pending_access.size() != 0 || in_valid || reply_q.size() != 0);
	endtask

	task automatic set_mode(input logic [MODE_W-1:0] mode);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// input driver
	always @(negedge clk) begin : feed
		access_t nxt;
		if (arst_n && !(in_valid && !in_taken)) begin
			if (in_wait > 0) begin
				in_wait <= in_wait - 1;
				in_valid <= 1'b0;
			end else if (pending_access.size() > 0) begin
				nxt = pending_access.pop_front();
				in_valid <= 1'b1;
				command <= nxt.cmd;
				address <= nxt.addr;
				write_data <= nxt.wdata;
				in_wait <= draw_wait(in_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result-side backpressure
	always @(negedge clk) begin : sink
		if (arst_n) begin
			if (out_taken)
				out_hold = draw_wait(out_calm);
			if (out_hold > 0) begin
				out_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor: check replies, then predict for the accepted access
	always @(posedge clk) begin : watch
		reply_t want;
		in_taken <= (in_valid && in_ready) === 1'b1;
		out_taken <= (out_valid && out_ready) === 1'b1;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d replies outstanding",
					cycle_count, reply_q.size());
				$display("[FAIL] regression broken");
				$finish;
			end
			if ((cfg_valid && cfg_ready) === 1'b1)
				shadow_mode = cfg_data;
			if ((out_valid && out_ready) === 1'b1) begin
				if (reply_q.size() == 0) begin
					bad_count++;
					if (bad_count <= MAX_REPORTS)
						$display("%0t: reply transfer with nothing outstanding", $realtime);
				end else begin
					want = reply_q.pop_front();
					if (hit !== want.hit || read_data !== want.read_data
							|| miss_count !== want.miss_count) begin
						bad_count++;
						if (bad_count <= MAX_REPORTS)
							$display("%0t: mismatch hit %b/%b read_data %h/%h miss_count %0d/%0d (exp/got)",
								$realtime, want.hit, hit, want.read_data, read_data,
								want.miss_count, miss_count);
					end
				end
			end
			if ((in_valid && in_ready) === 1'b1)
				reply_q = {reply_q, cache_access(command, address, write_data)};
		end
	end

	initial begin : stimulus
		logic [MODE_W-1:0] mode_seq [9];
		mode_seq = '{MODE_FA, MODE_SA, MODE_DM, MODE_SA_ALT, MODE_FA,
			MODE_DM, MODE_SA, MODE_FA, MODE_SA};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// direct mapped: miss, hit, no-allocate store, conflict eviction, nops
		set_mode(MODE_DM);
		queue_access(CMD_LOAD, 0, 32'h0);
		queue_access(CMD_STORE, 0, 32'h7fff_ffff);
		queue_access(CMD_LOAD, 0, 32'hffff_ffff);
		queue_access(CMD_STORE, 2047, 32'h8000_0000);
		queue_access(CMD_LOAD, 2047, 32'h0);
		queue_access(CMD_LOAD, 2047, 32'h0);
		queue_access(CMD_LOAD, 16, 32'h0);
		queue_access(CMD_LOAD, 0, 32'h0);
		queue_access(CMD_NOP, 2047, 32'hffff_ffff);
		queue_access(CMD_SPARE, 5, 32'hffff_ffff);
		drain();

		// fully associative over lines left from direct mapped (stale tag hit on 127)
		set_mode(MODE_FA);
		queue_access(CMD_LOAD, 0, 32'h0);
		queue_access(CMD_LOAD, 127, 32'h0);
		queue_access(CMD_STORE, 5, 32'hffff_ffff);
		queue_access(CMD_LOAD, 5, 32'h0);
		queue_access(CMD_LOAD, 5, 32'h0);
		queue_access(CMD_STORE, 1024, 32'h0000_0001);
		queue_access(CMD_LOAD, 1024, 32'h0);
		drain();

		// set associative: overfill set 1 so the least recent way is evicted
		set_mode(MODE_SA);
		queue_access(CMD_LOAD, 1, 32'h0);
		queue_access(CMD_LOAD, 5, 32'h0);
		queue_access(CMD_LOAD, 9, 32'h0);
		queue_access(CMD_LOAD, 13, 32'h0);
		queue_access(CMD_LOAD, 17, 32'h0);
		queue_access(CMD_LOAD, 1, 32'h0);
		queue_access(CMD_STORE, 1, 32'h8000_0000);
		queue_access(CMD_LOAD, 1, 32'h0);
		drain();

		foreach (mode_seq[p]) begin
			set_mode(mode_seq[p]);
			for (int i = 0; i < HOT_N; i++)
				hot_addr[i] = ADDR_W'($urandom_range(0, MEM_DEPTH - 1));
			repeat (PHASE_ITEMS)
				pending_access = {pending_access, random_access()};
			drain();
		end

		repeat (8) @(posedge clk);
		if (bad_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[cache_controller_dm_fa_sa_lru.f]
hdl/ccache_pkg.sv
hdl/ccache_mem.sv
hdl/ccache_lines.sv
hdl/cache_controller_dm_fa_sa_lru.sv
hdl/ccache_chk.sv
sim/cache_controller_dm_fa_sa_lru_tb.sv
